@@ rtl/core/atr_pkg.sv @@
// ----------------------------------------------------------------------------
// atr_pkg
// Shared widths, register map and link types for the average true range block.
// ----------------------------------------------------------------------------
package atr_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int PRICE_BITS   = 32;
   localparam int PTR_BITS     = $clog2(MAX_WINDOW);
   localparam int LEN_BITS     = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS     = PRICE_BITS + PTR_BITS;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
   localparam int OUT_BITS     = 32;

   // Register map
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int WLEN_BITS     = 7;
   localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd14;
   localparam logic [CSR_ADDR_BITS-3:0] REG_WINDOW_LENGTH = 1'b0;

   // Ring write port
   typedef struct packed {
      logic                  en;
      logic [PTR_BITS-1:0]   addr;
      logic [PRICE_BITS-1:0] data;
   } ring_wr_type;

   // Divider start request
   typedef struct packed {
      logic                start;
      logic [SUM_BITS-1:0] dividend;
      logic [LEN_BITS-1:0] divisor;
   } div_req_type;

   // Divider result
   typedef struct packed {
      logic                done;
      logic [SUM_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/core/atr_ring.sv @@
// ----------------------------------------------------------------------------
// atr_ring
// True range ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module atr_ring (
   input  logic                           clock,
   input  atr_pkg::ring_wr_type           wr,
   input  logic                           rd_en,
   input  logic [atr_pkg::PTR_BITS-1:0]   rd_addr,
   output logic [atr_pkg::PRICE_BITS-1:0] rd_data
);

   logic [atr_pkg::PRICE_BITS-1:0] mem [atr_pkg::MAX_WINDOW];
   logic [atr_pkg::PRICE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/atr_divider.sv @@
// ----------------------------------------------------------------------------
// atr_divider
// Restoring divider: window sum over window length, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module atr_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  atr_pkg::div_req_type req,
   output atr_pkg::div_rsp_type rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [atr_pkg::DIV_CNT_BITS-1:0]   count_ff, count_in;
   logic [atr_pkg::SUM_BITS-1:0]       quo_ff, quo_in;
   logic [atr_pkg::LEN_BITS-1:0]       rem_ff, rem_in;
   logic [atr_pkg::LEN_BITS-1:0]       divisor_ff, divisor_in;
   logic [atr_pkg::LEN_BITS:0]         rem_shift;
   logic [atr_pkg::LEN_BITS:0]         rem_diff;
   logic                               fits;

   always_comb begin
      rem_shift  = {rem_ff, quo_ff[atr_pkg::SUM_BITS-1]};
      rem_diff   = rem_shift - {1'b0, divisor_ff};
      fits       = (rem_shift >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         // load operands, first bit comes out next cycle
         busy_in    = 1'b1;
         count_in   = atr_pkg::DIV_CNT_BITS'(atr_pkg::SUM_BITS - 1);
         quo_in     = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[atr_pkg::SUM_BITS-2:0], fits};
         rem_in = fits ? rem_diff[atr_pkg::LEN_BITS-1:0] : rem_shift[atr_pkg::LEN_BITS-1:0];
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

@@ rtl/core/average_true_range.sv @@
// ----------------------------------------------------------------------------
// average_true_range
// True range of each price bar and its simple moving average over a window.
// ----------------------------------------------------------------------------
//
//   port group | direction | handshake          | contents
//   req_       | in        | req_valid/req_stall | bar_high, bar_low, bar_close
//   rsp_       | out       | rsp_valid/rsp_stall | true_range, average_range,
//              |           |                     | average_valid
//   csr_       | in/out    | APB write/read      | window_length at byte 0
//
// A request passes through idle, which takes the request; range, which forms
// the true range and reads the ring; sum, which updates the sum and writes the
// ring; once the window is full, the restoring divider (one quotient bit per
// bit of the window sum) and its hand-off; and done, which loads the output
// register. While the window is still filling, the divider is skipped.
// The ring memory has a single write and a single read port with
// registered read data; each request reads and then writes one entry.
// Reset is synchronous: it clears the stream state and sets window_length
// to 14. The ring is not cleared; an entry's value is only used once written.
// A finished result waits in the output register while the next request is
// taken in; the block holds in its final state only when that register is
// still full and stalled.
// ----------------------------------------------------------------------------
module average_true_range (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [atr_pkg::PRICE_BITS-1:0]    req_bar_high,
   input  logic [atr_pkg::PRICE_BITS-1:0]    req_bar_low,
   input  logic [atr_pkg::PRICE_BITS-1:0]    req_bar_close,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [atr_pkg::OUT_BITS-1:0]      rsp_true_range,
   output logic [atr_pkg::OUT_BITS-1:0]      rsp_average_range,
   output logic                              rsp_average_valid,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [atr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [atr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [atr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RANGE = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // Absolute difference of two prices
   function automatic logic [atr_pkg::PRICE_BITS-1:0] abs_diff(
      input logic [atr_pkg::PRICE_BITS-1:0] a,
      input logic [atr_pkg::PRICE_BITS-1:0] b
   );
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   // Control state
   logic [2:0]                       state_ff, state_in;
   logic [atr_pkg::WLEN_BITS-1:0]    wlen_ff, wlen_in;
   logic [atr_pkg::PTR_BITS-1:0]     ptr_ff, ptr_in;
   logic [atr_pkg::LEN_BITS-1:0]     seen_ff, seen_in;
   logic [atr_pkg::SUM_BITS-1:0]     sum_ff, sum_in;
   logic                             have_prev_ff, have_prev_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [atr_pkg::PRICE_BITS-1:0]   prev_close_ff, prev_close_in;
   logic [atr_pkg::PRICE_BITS-1:0]   high_ff, high_in;
   logic [atr_pkg::PRICE_BITS-1:0]   low_ff, low_in;
   logic [atr_pkg::PRICE_BITS-1:0]   close_ff, close_in;
   logic [atr_pkg::PRICE_BITS-1:0]   tr_ff, tr_in;
   logic [atr_pkg::PTR_BITS-1:0]     slot_ff, slot_in;
   logic                             avg_valid_ff, avg_valid_in;
   logic [atr_pkg::OUT_BITS-1:0]     avg_ff, avg_in;
   logic [atr_pkg::OUT_BITS-1:0]     rsp_tr_ff, rsp_tr_in;
   logic [atr_pkg::OUT_BITS-1:0]     rsp_avg_ff, rsp_avg_in;
   logic                             rsp_avg_valid_ff, rsp_avg_valid_in;

   // Datapath helpers
   logic                             csr_write;
   logic [atr_pkg::LEN_BITS-1:0]     eff_len;
   logic [atr_pkg::PTR_BITS-1:0]     slot_now;
   logic [atr_pkg::LEN_BITS-1:0]     slot_next;
   logic [atr_pkg::PRICE_BITS-1:0]   hl_range;
   logic [atr_pkg::PRICE_BITS-1:0]   hc_range;
   logic [atr_pkg::PRICE_BITS-1:0]   lc_range;
   logic [atr_pkg::PRICE_BITS-1:0]   tr_calc;
   logic                             window_full;
   logic [atr_pkg::SUM_BITS-1:0]     sum_drop;
   logic                             out_free;

   // Submodule links
   atr_pkg::ring_wr_type             ring_wr;
   logic                             ring_rd_en;
   logic [atr_pkg::PRICE_BITS-1:0]   ring_rd_data;
   atr_pkg::div_req_type             div_req;
   atr_pkg::div_rsp_type             div_rsp;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[atr_pkg::CSR_ADDR_BITS-1:2] == atr_pkg::REG_WINDOW_LENGTH);
   assign csr_pready = 1'b1;
   assign csr_prdata = atr_pkg::CSR_DATA_BITS'(wlen_ff);

   // Effective window: zero acts as one, large values clamp to the ring depth
   always_comb begin
      if (wlen_ff == '0) begin
         eff_len = atr_pkg::LEN_BITS'(1);
      end else if (int'(wlen_ff) > atr_pkg::MAX_WINDOW) begin
         eff_len = atr_pkg::LEN_BITS'(atr_pkg::MAX_WINDOW);
      end else begin
         eff_len = atr_pkg::LEN_BITS'(wlen_ff);
      end
   end

   // Slot wraps at the window, so a shortened window never reads past it
   assign slot_now  = ({1'b0, ptr_ff} >= eff_len) ? '0 : ptr_ff;
   assign slot_next = {1'b0, slot_ff} + 1'b1;

   // True range of the captured bar
   always_comb begin
      hl_range = (high_ff >= low_ff) ? (high_ff - low_ff) : '0;
      hc_range = abs_diff(high_ff, prev_close_ff);
      lc_range = abs_diff(low_ff, prev_close_ff);
      tr_calc  = hl_range;
      if (have_prev_ff) begin
         if (hc_range > tr_calc) begin
            tr_calc = hc_range;
         end
         if (lc_range > tr_calc) begin
            tr_calc = lc_range;
         end
      end
   end

   assign window_full = (seen_ff >= eff_len);
   assign sum_drop    = window_full ? atr_pkg::SUM_BITS'(ring_rd_data) : '0;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      wlen_in          = wlen_ff;
      ptr_in           = ptr_ff;
      seen_in          = seen_ff;
      sum_in           = sum_ff;
      have_prev_in     = have_prev_ff;
      prev_close_in    = prev_close_ff;
      high_in          = high_ff;
      low_in           = low_ff;
      close_in         = close_ff;
      tr_in            = tr_ff;
      slot_in          = slot_ff;
      avg_valid_in     = avg_valid_ff;
      avg_in           = avg_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_tr_in        = rsp_tr_ff;
      rsp_avg_in       = rsp_avg_ff;
      rsp_avg_valid_in = rsp_avg_valid_ff;
      ring_rd_en       = 1'b0;
      ring_wr          = '{en: 1'b0, addr: slot_ff, data: tr_ff};
      div_req          = '{start: 1'b0, dividend: '0, divisor: eff_len};

      // drop the result once the far side takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               high_in  = req_bar_high;
               low_in   = req_bar_low;
               close_in = req_bar_close;
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            // form the range and fetch the entry that leaves the window
            tr_in         = tr_calc;
            slot_in       = slot_now;
            ring_rd_en    = 1'b1;
            prev_close_in = close_ff;
            have_prev_in  = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            // retire the oldest range, add the new one, advance the ring
            sum_in     = sum_ff - sum_drop + atr_pkg::SUM_BITS'(tr_ff);
            ring_wr.en = 1'b1;
            ptr_in     = (slot_next >= eff_len) ? '0 : slot_next[atr_pkg::PTR_BITS-1:0];
            if (!window_full) begin
               seen_in = seen_ff + 1'b1;
            end
            if (window_full || (seen_ff + 1'b1 >= eff_len)) begin
               avg_valid_in     = 1'b1;
               div_req.start    = 1'b1;
               div_req.dividend = sum_in;
               state_in         = ST_DIV;
            end else begin
               avg_valid_in = 1'b0;
               avg_in       = '0;
               state_in     = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient[atr_pkg::OUT_BITS-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_tr_in        = atr_pkg::OUT_BITS'(tr_ff);
               rsp_avg_in       = avg_ff;
               rsp_avg_valid_in = avg_valid_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // window write restarts stream; user must do it only while idle, unenforced
      if (csr_write) begin
         wlen_in      = csr_pwdata[atr_pkg::WLEN_BITS-1:0];
         ptr_in       = '0;
         seen_in      = '0;
         sum_in       = '0;
         have_prev_in = 1'b0;
         prev_close_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wlen_ff       <= atr_pkg::WLEN_RESET;
         ptr_ff        <= '0;
         seen_ff       <= '0;
         sum_ff        <= '0;
         have_prev_ff  <= 1'b0;
         prev_close_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wlen_ff       <= wlen_in;
         ptr_ff        <= ptr_in;
         seen_ff       <= seen_in;
         sum_ff        <= sum_in;
         have_prev_ff  <= have_prev_in;
         prev_close_ff <= prev_close_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      high_ff          <= high_in;
      low_ff           <= low_in;
      close_ff         <= close_in;
      tr_ff            <= tr_in;
      slot_ff          <= slot_in;
      avg_valid_ff     <= avg_valid_in;
      avg_ff           <= avg_in;
      rsp_tr_ff        <= rsp_tr_in;
      rsp_avg_ff       <= rsp_avg_in;
      rsp_avg_valid_ff <= rsp_avg_valid_in;
   end

   atr_ring u_ring (
      .clock   (clock),
      .wr      (ring_wr),
      .rd_en   (ring_rd_en),
      .rd_addr (slot_now),
      .rd_data (ring_rd_data)
   );

   atr_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_true_range    = rsp_tr_ff;
   assign rsp_average_range = rsp_avg_ff;
   assign rsp_average_valid = rsp_avg_valid_ff;

endmodule

@@ rtl/core/atr_checker.sv @@
// ----------------------------------------------------------------------------
// atr_checker
// Port-level checks for the average true range block, bound to the top level.
// ----------------------------------------------------------------------------
module atr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [atr_pkg::OUT_BITS-1:0] rsp_true_range,
   input logic [atr_pkg::OUT_BITS-1:0] rsp_average_range,
   input logic                         rsp_average_valid,
   input logic                         csr_pready
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // average stays zero until the window has filled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_average_valid) |-> (rsp_average_range == '0))
      else $error("average given before window is full");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_true_range) && $stable(rsp_average_range)
          && $stable(rsp_average_valid)))
      else $error("stalled result changed");

   // one request at a time: busy right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

   // configuration port never waits
   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("configuration port not ready");

endmodule

bind average_true_range atr_checker u_atr_checker (.*);
